### rtl/mvt_pkg.sv
// ----------------------------------------------------------------------------
// Matrix-vector transform package
// Word format, operation codes, the item travelling down the cell chain and
// the conversions between the 32-bit port fields and the internal word.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int FIELD_BITS = 32;
   localparam int NUM_CELLS  = 4;
   localparam int TP_SIZE    = 3;
   localparam int LAST_CELL  = NUM_CELLS - 1;

   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic signed [FIELD_BITS-1:0]  field_type;
   typedef logic signed [2*WORD_BITS-1:0] prod_type;
   typedef logic [2:0]                    op_type;
   typedef logic [$clog2(NUM_CELLS)-1:0]  idx_type;

   localparam op_type OP_WRITE_ROW = 3'd0;
   localparam op_type OP_VEC4      = 3'd1;
   localparam op_type OP_POINT     = 3'd2;
   localparam op_type OP_NORMAL    = 3'd3;
   localparam op_type OP_TRANSPOSE = 3'd4;

   localparam word_type ONE_FP = word_type'(1) << FRAC_BITS;

   // One item in flight: the request itself and the partial row sums.
   typedef struct packed {
      logic                         valid;
      op_type                       op;
      idx_type                      row;
      word_type [NUM_CELLS-1:0]     vec;
      word_type [NUM_CELLS-1:0]     acc;
   } token_type;

   function automatic word_type to_word(input field_type f);
      return word_type'(f);
   endfunction

   function automatic field_type to_field(input word_type w);
      return field_type'(w);
   endfunction

   function automatic logic has_result(input op_type op);
      return op inside {OP_VEC4, OP_POINT, OP_NORMAL};
   endfunction

endpackage

### rtl/mvt_if.sv
// ----------------------------------------------------------------------------
// Matrix-vector transform channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mvt_req_if;
   import mvt_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   idx_type   row_index;
   field_type in_x;
   field_type in_y;
   field_type in_z;
   field_type in_w;

   modport source (output valid, operation, row_index, in_x, in_y, in_z, in_w,
                   input ready);
   modport sink   (input valid, operation, row_index, in_x, in_y, in_z, in_w,
                   output ready);
endinterface

interface mvt_rsp_if;
   import mvt_pkg::*;

   logic      valid;
   logic      ready;
   field_type out_x;
   field_type out_y;
   field_type out_z;
   field_type out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

### rtl/mvt_cell.sv
// ----------------------------------------------------------------------------
// Matrix-vector transform column cell
// Holds one matrix column plus the upper part of the matching row, applies
// row writes and transposes as items pass, and adds its column's products
// into the four running row sums.
// ----------------------------------------------------------------------------
module mvt_cell (
   input  logic                clock,
   input  logic                reset,
   input  mvt_pkg::idx_type    cell_idx,
   input  logic                advance,
   input  mvt_pkg::token_type  up_tok,
   output mvt_pkg::token_type  dn_tok
);
   import mvt_pkg::*;

   word_type  col_ff [NUM_CELLS];
   word_type  col_in [NUM_CELLS];
   word_type  row_ff [TP_SIZE];
   word_type  row_in [TP_SIZE];
   logic      valid_ff;
   logic      valid_in;
   token_type tok_ff;
   token_type tok_in;
   prod_type  prod [NUM_CELLS];
   word_type  lane_v;
   logic      take;
   logic      transposes;

   // The row copy duplicates what the other cells hold as columns, so a
   // transpose of the upper block is a local swap of the two copies.
   always_comb begin
      take       = advance && up_tok.valid;
      transposes = cell_idx != idx_type'(LAST_CELL);
      lane_v     = up_tok.vec[cell_idx];
      valid_in   = up_tok.valid;
      col_in     = col_ff;
      row_in     = row_ff;
      if (take) begin
         case (up_tok.op)
            OP_WRITE_ROW: begin
               col_in[up_tok.row] = lane_v;
               if (up_tok.row == cell_idx) begin
                  for (int c = 0; c < TP_SIZE; c++) begin
                     row_in[c] = up_tok.vec[c];
                  end
               end
            end
            OP_TRANSPOSE: begin
               if (transposes) begin
                  for (int c = 0; c < TP_SIZE; c++) begin
                     col_in[c] = row_ff[c];
                     row_in[c] = col_ff[c];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      tok_in = up_tok;
      for (int r = 0; r < NUM_CELLS; r++) begin
         prod[r] = prod_type'(col_ff[r]) * prod_type'(lane_v);
         tok_in.acc[r] = up_tok.acc[r] + word_type'(prod[r][FRAC_BITS +: WORD_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int r = 0; r < NUM_CELLS; r++) begin
            col_ff[r] <= (idx_type'(r) == cell_idx) ? ONE_FP : '0;
         end
         for (int c = 0; c < TP_SIZE; c++) begin
            row_ff[c] <= (idx_type'(c) == cell_idx) ? ONE_FP : '0;
         end
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tok_ff <= tok_in;
      end
   end

   always_comb begin
      dn_tok       = tok_ff;
      dn_tok.valid = valid_ff;
   end

endmodule

### rtl/mat4_vector_transform_fixed.sv
// ----------------------------------------------------------------------------
// Fixed-point 4x4 matrix-vector transform
// Chain of four column cells that stores a 16.16 matrix and transforms
// vectors, points and normals by it.
// ----------------------------------------------------------------------------
// Usage:
// Each request item carries an operation, a row index and four 16.16 words.
// Row writes and transposes update the stored matrix and return nothing; the
// vec4, point and normal operations each return one result item on rsp.
// Items pass through the four column cells in order, each cell applying
// its column's four multiply-adds, and a result is presented from the last
// cell's register until it is taken.
// One item is accepted per cycle while the chain is not stalled; the cell
// chain takes a new item every cycle unless a waiting result holds it.
// Matrix updates take effect in item order, so a transform issued right
// after a row write or transpose already sees the new matrix.
// Reset (synchronous) empties the chain and loads the identity matrix.
// When the receiver stalls, the result waits in the last cell; cells behind
// it keep filling until the chain is full, then req.ready drops.
// ----------------------------------------------------------------------------
module mat4_vector_transform_fixed (
   input  logic        clock,
   input  logic        reset,
   mvt_req_if.sink     req,
   mvt_rsp_if.source   rsp
);
   import mvt_pkg::*;

   token_type src_tok;
   token_type tok [NUM_CELLS];
   logic      en  [NUM_CELLS];

   always_comb begin
      src_tok       = '0;
      src_tok.valid = req.valid;
      src_tok.op    = req.operation;
      src_tok.row   = req.row_index;
      src_tok.vec[0] = to_word(req.in_x);
      src_tok.vec[1] = to_word(req.in_y);
      src_tok.vec[2] = to_word(req.in_z);
      case (req.operation)
         OP_POINT:  src_tok.vec[3] = ONE_FP;
         OP_NORMAL: src_tok.vec[3] = '0;
         default:   src_tok.vec[3] = to_word(req.in_w);
      endcase
   end

   // A cell moves on when it is empty or the cell after it moves on; the last
   // cell only blocks while it holds a result that has not been taken.
   always_comb begin
      en[LAST_CELL] = !(tok[LAST_CELL].valid && has_result(tok[LAST_CELL].op))
                      || rsp.ready;
      for (int j = LAST_CELL - 1; j >= 0; j--) begin
         en[j] = !tok[j].valid || en[j+1];
      end
   end

   for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
      if (j == 0) begin : g_first
         mvt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (idx_type'(j)),
            .advance  (en[j]),
            .up_tok   (src_tok),
            .dn_tok   (tok[j])
         );
      end else begin : g_next
         mvt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (idx_type'(j)),
            .advance  (en[j]),
            .up_tok   (tok[j-1]),
            .dn_tok   (tok[j])
         );
      end
   end

   assign req.ready = en[0];
   assign rsp.valid = tok[LAST_CELL].valid && has_result(tok[LAST_CELL].op);
   assign rsp.out_x = to_field(tok[LAST_CELL].acc[0]);
   assign rsp.out_y = to_field(tok[LAST_CELL].acc[1]);
   assign rsp.out_z = to_field(tok[LAST_CELL].acc[2]);
   assign rsp.out_w = (tok[LAST_CELL].op == OP_VEC4) ?
                      to_field(tok[LAST_CELL].acc[3]) : '0;

`ifndef SYNTH
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req.ready)
      else $error("chain not empty after reset");

   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> tok[0].valid)
      else $error("accepted item missing from first cell");

   a_stall_keeps_items: assert property (@(posedge clock) disable iff (reset)
      tok[2].valid && !en[LAST_CELL] |=> tok[2].valid && tok[LAST_CELL].valid)
      else $error("item lost while the last cell was stalled");
`endif

endmodule
